// ----- hdl/ost_pkg.sv -----
// shared types and constants for the ordered set table
package ost_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // field widths of the transaction ports
  localparam int MODE_W     = 2;
  localparam int IN_VALUE_W = 32;
  localparam int POSITION_W = 4;
  localparam int COUNT_W    = 5;

  // request modes, an unused code acts as find
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic load_match;
    logic apply;
  } ctrl_cmd_t;

endpackage

// ----- hdl/ordered_set_table_top.sv -----
// top level of the ordered set table
// Ordered set table: holds up to CAPACITY distinct values in insertion order.
// Each request transaction (mode, value) gives exactly one result transaction:
// insert appends an absent value or is refused when the table is full, remove
// deletes a match and closes the gap, find (and the unused mode code) changes
// nothing. A request passes through the idle, match and apply states: the accepting
// cycle latches it, the match step does the registered parallel compare across all
// entries, and the apply step updates the entry registers and loads the result
// register. The entry registers are shared by these steps, so one request is in
// flight at a time; a new one is taken only after the last has left the apply step.
// A waiting result does not block the next request from being accepted, but that
// request holds in its last step until the waiting result is taken, and the input
// stalls meanwhile.
module ordered_set_table_top #(
  parameter int CAPACITY   = ost_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ost_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ost_pkg::MODE_W-1:0]     mode,
  input  logic [ost_pkg::IN_VALUE_W-1:0] value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic [ost_pkg::POSITION_W-1:0] position,
  output logic                           refused,
  output logic [ost_pkg::COUNT_W-1:0]    entry_count
);

  ost_pkg::ctrl_cmd_t cmd;

  // sequencing
  ost_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // storage and compare
  ost_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .value       (value),
    .found       (found),
    .position    (position),
    .refused     (refused),
    .entry_count (entry_count)
  );

endmodule

// ----- hdl/ost_ctrl.sv -----
// controller state machine for the ordered set table
module ost_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ost_pkg::ctrl_cmd_t cmd
);

  ost_pkg::state_t state;
  ost_pkg::state_t state_next;
  logic            out_valid_next;

  // state register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ost_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ost_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ost_pkg::ST_MATCH;
        end
      end
      ost_pkg::ST_MATCH: begin
        cmd.load_match = 1'b1;
        state_next     = ost_pkg::ST_APPLY;
      end
      ost_pkg::ST_APPLY: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.apply      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ost_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ost_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ost_dp.sv -----
// entry registers, match logic and result registers of the ordered set table
module ost_dp #(
  parameter int CAPACITY   = ost_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ost_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ost_pkg::ctrl_cmd_t             cmd,
  input  logic [ost_pkg::MODE_W-1:0]     mode,
  input  logic [ost_pkg::IN_VALUE_W-1:0] value,
  output logic                           found,
  output logic [ost_pkg::POSITION_W-1:0] position,
  output logic                           refused,
  output logic [ost_pkg::COUNT_W-1:0]    entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [VALUE_BITS-1:0]      entries [CAPACITY];
  logic [CNT_W-1:0]           count;
  logic [ost_pkg::MODE_W-1:0] req_mode;
  logic [VALUE_BITS-1:0]      req_value;
  logic [CAPACITY-1:0]        hit_vec;
  logic [CAPACITY-1:0]        hit_vec_next;
  logic                       hit;
  logic [IDX_W-1:0]           hit_idx;
  logic                       do_insert;
  logic                       do_remove;
  logic                       is_full;

  // latch the request transaction
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode  <= mode;
      req_value <= VALUE_BITS'(value);
    end
  end

  // parallel compare against valid entries
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec_next[i] = (CNT_W'(i) < count) && (entries[i] == req_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_vec <= '0;
    end else if (cmd.load_match) begin
      hit_vec <= hit_vec_next;
    end
  end

  // values are distinct, so at most one bit is set and an or tree encodes it
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit       = |hit_vec;
  assign is_full   = (count == CAP_CNT);
  assign do_insert = (req_mode == ost_pkg::MODE_INSERT) && !hit && !is_full;
  assign do_remove = (req_mode == ost_pkg::MODE_REMOVE) && hit;

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      if (do_insert) begin
        count <= count + CNT_W'(1);
      end else if (do_remove) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // append at the tail or close the gap after a removed entry
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (do_insert) begin
        entries[count[IDX_W-1:0]] <= req_value;
      end else if (do_remove) begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (IDX_W'(i) >= hit_idx) begin
            entries[i] <= entries[i + 1];
          end
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      found       <= hit;
      position    <= ost_pkg::POSITION_W'(hit_idx);
      refused     <= (req_mode == ost_pkg::MODE_INSERT) && !hit && is_full;
      entry_count <= ost_pkg::COUNT_W'(do_insert ? count + CNT_W'(1) :
                                       do_remove ? count - CNT_W'(1) : count);
    end
  end

  // stored values never repeat
  a_single_hit: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_vec))
    else $error("more than one entry matched");

  // fill count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CAP_CNT)
    else $error("fill count beyond capacity");

  // a refused insert never reports a hit
  a_refused_miss: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> !(refused && found))
    else $error("refused and found both set");

  // reported count follows the fill count
  a_count_out: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> entry_count == ost_pkg::COUNT_W'(count))
    else $error("result count differs from fill count");

endmodule

// ----- tb/tb.sv -----
// testbench for the ordered set table: directed, random and back-pressure runs
`timescale 1ns / 1ps

module tb;

  localparam int                         CAP         = ost_pkg::CAPACITY_DEF;
  localparam logic [ost_pkg::MODE_W-1:0] MODE_SPARE  = 2'd3;
  localparam int                         HOLD_CYCLES = 200;
  localparam int                         WATCHDOG    = 3000;
  localparam int                         POOL_SIZE   = 24;

  // one result transaction
  typedef struct packed {
    logic                           found;
    logic [ost_pkg::POSITION_W-1:0] position;
    logic                           refused;
    logic [ost_pkg::COUNT_W-1:0]    entry_count;
  } set_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [ost_pkg::MODE_W-1:0]     mode = '0;
  logic [ost_pkg::IN_VALUE_W-1:0] value = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           found;
  logic [ost_pkg::POSITION_W-1:0] position;
  logic                           refused;
  logic [ost_pkg::COUNT_W-1:0]    entry_count;

  // predicted table contents and the results still owed
  logic [ost_pkg::IN_VALUE_W-1:0] held_vals [CAP];
  int                             held_count = 0;
  set_result_t                    pending_results [$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_req       = 1'b0;
  logic out_hold      = 1'b0;
  int  fail_count     = 0;
  int  requests_sent  = 0;
  int  results_seen   = 0;
  int  hits_seen      = 0;
  int  refusals_seen  = 0;
  int  full_seen      = 0;
  int  quiet_cycles   = 0;

  ordered_set_table_top DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .position    (position),
    .refused     (refused),
    .entry_count (entry_count)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // predict one request and update the table copy
  function automatic set_result_t apply_request(
    input logic [ost_pkg::MODE_W-1:0]     m,
    input logic [ost_pkg::IN_VALUE_W-1:0] v
  );
    set_result_t r;
    int          hit_at;
    r = '0;
    hit_at = -1;
    for (int i = 0; i < held_count; i++) begin
      if (hit_at < 0 && held_vals[i] == v) hit_at = i;
    end
    r.found = (hit_at >= 0);
    r.position = r.found ? hit_at[ost_pkg::POSITION_W-1:0] : '0;
    case (m)
      ost_pkg::MODE_INSERT: begin
        if (hit_at < 0) begin
          if (held_count < CAP) begin
            held_vals[held_count] = v;
            held_count++;
          end else begin
            r.refused = 1'b1;
          end
        end
      end
      ost_pkg::MODE_REMOVE: begin
        if (hit_at >= 0) begin
          for (int i = hit_at; i + 1 < held_count; i++) held_vals[i] = held_vals[i + 1];
          held_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = held_count[ost_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // send one request transaction, with random idle cycles ahead of it
  task automatic send_request(input logic [ost_pkg::MODE_W-1:0]     m,
                              input logic [ost_pkg::IN_VALUE_W-1:0] v);
    set_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(m, v);
    pending_results = {pending_results, predicted};
    requests_sent++;
    if (held_count == CAP) full_seen++;
  endtask

  // receiver stall, random plus the long hold-off
  always @(posedge clk) begin
    out_stall <= out_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off, counted here once requested
  initial begin
    wait (hold_req);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    set_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: found %0d position %0d refused %0d count %0d",
               found, position, refused, entry_count);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.found) hits_seen++;
        if (exp_r.refused) refusals_seen++;
        if (found !== exp_r.found) begin
          $error("found: expected %0d, actual %0d", exp_r.found, found);
          fail_count++;
        end
        if (position !== exp_r.position) begin
          $error("position: expected %0d, actual %0d", exp_r.position, position);
          fail_count++;
        end
        if (refused !== exp_r.refused) begin
          $error("refused: expected %0d, actual %0d", exp_r.refused, refused);
          fail_count++;
        end
        if (entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", exp_r.entry_count, entry_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("timeout: no transaction in %0d cycles", WATCHDOG);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // edges of the value range, duplicates, fill to full, refusal, removals
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(ost_pkg::MODE_FIND, 32'h0000_0000);
    send_request(ost_pkg::MODE_INSERT, 32'h0000_0000);
    send_request(ost_pkg::MODE_INSERT, 32'hFFFF_FFFF);
    send_request(ost_pkg::MODE_INSERT, 32'h0000_0000);
    send_request(ost_pkg::MODE_FIND, 32'hFFFF_FFFF);
    send_request(ost_pkg::MODE_REMOVE, 32'h1234_5678);
    send_request(ost_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
    for (int i = 1; i < CAP; i++) send_request(ost_pkg::MODE_INSERT, 32'hA5A5_0000 + i);
    send_request(ost_pkg::MODE_INSERT, 32'h5A5A_FFFF);
    send_request(ost_pkg::MODE_INSERT, 32'hA5A5_0007);
    send_request(ost_pkg::MODE_REMOVE, 32'h0000_0000);
    send_request(MODE_SPARE, 32'hA5A5_000F);
    send_request(ost_pkg::MODE_REMOVE, 32'hA5A5_0008);
  endtask

  // random requests drawn mostly from a small pool so hits and a full table are common
  task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
    logic [ost_pkg::IN_VALUE_W-1:0] pool [POOL_SIZE];
    logic [ost_pkg::MODE_W-1:0]     m;
    logic [ost_pkg::IN_VALUE_W-1:0] v;
    int                             ins_w;
    int                             roll;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    ins_w = 50;
    foreach (pool[i]) pool[i] = $urandom();
    pool[0] = '0;
    pool[1] = '1;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) ins_w = $urandom_range(20, 80);
      roll = $urandom_range(99);
      if (roll < ins_w) m = ost_pkg::MODE_INSERT;
      else if (roll < ins_w + (100 - ins_w) * 2 / 3) m = ost_pkg::MODE_REMOVE;
      else if (roll < 97) m = ost_pkg::MODE_FIND;
      else m = MODE_SPARE;
      roll = $urandom_range(9);
      if (roll == 0) v = $urandom();
      else if (roll < 5 && m != ost_pkg::MODE_INSERT && held_count > 0)
        v = held_vals[$urandom_range(held_count - 1)];
      else v = pool[$urandom_range(POOL_SIZE - 1)];
      send_request(m, v);
    end
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    for (int k = 0; k < 40; k++) begin
      send_request((k % 3 == 0) ? ost_pkg::MODE_REMOVE : ost_pkg::MODE_INSERT,
                   32'hC0DE_0000 + (k % 20));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(270, 0, 0);
    test_random(270, 72, 0);
    test_random(270, 0, 72);
    test_random(270, 22, 22);
    test_backpressure();
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d requests, %0d results checked: %0d hits, %0d refused inserts,",
             requests_sent, results_seen, hits_seen, refusals_seen);
    $display("table full after %0d requests, idle and stall phases plus a long hold-off",
             full_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
